// ===== design/set_assoc_cache_tag_store_core_assert.svh =====
// Assertion helpers used by the tag store back end.
`ifndef SET_ASSOC_CACHE_TAG_STORE_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_STORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SACTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SACTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sacts_pkg.sv =====
`default_nettype none
package sacts_pkg;
	localparam int DEF_SETS           = 256;
	localparam int DEF_WAYS           = 8;
	localparam int DEF_LINE_ADDR_BITS = 40;
	localparam int TAG_W              = 32;
	localparam int STAMP_W            = 32;
	localparam int SET_MAX_W          = 16;
	localparam int QUOTA_W            = 4;
	localparam int OUT_DATA_W         = 40;

	localparam logic CMD_LOOKUP  = 1'b0;
	localparam logic CMD_INSTALL = 1'b1;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_QUOTA  = 1'b1;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_PART = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic                 wr_flag;
		logic                 core_id;
		logic [TAG_W-1:0]     tag;
		logic [SET_MAX_W-1:0] set;
		logic [STAMP_W-1:0]   now;
	} req_t;

	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic               owner;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef struct packed {
		logic               policy;
		logic [QUOTA_W-1:0] quota;
	} cfg_t;

	typedef struct packed {
		logic             evicted_core;
		logic [TAG_W-1:0] evicted_tag;
		logic             evicted_dirty;
		logic             evicted_valid;
		logic [2:0]       victim_way;
		logic             hit;
	} res_t;
endpackage
`default_nettype wire

// ===== design/sacts_front.sv =====
`default_nettype none
module sacts_front
	import sacts_pkg::*;
#(
	parameter int SETS           = DEF_SETS,
	parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS
) (
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [LINE_ADDR_BITS-1:0] addr_in,
	input  wire logic                      wr_flag,
	input  wire logic                      core_id,
	input  wire logic [STAMP_W-1:0]        now,
	input  wire logic                      cmd,
	input  wire logic                      store_ready,
	input  wire logic                      q_full,
	output logic                           q_push,
	output req_t                           q_req
);
	localparam int IDX_BITS = $clog2(SETS + 1) - 1;

	logic [63:0] addr_ext;

	assign addr_ext = 64'(addr_in);
	assign s_tready = store_ready && !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_req         = '0;
		q_req.cmd     = cmd;
		q_req.wr_flag = wr_flag;
		q_req.core_id = core_id;
		q_req.now     = now;
		q_req.tag     = TAG_W'(addr_ext >> IDX_BITS);
		if (IDX_BITS > 0) begin
			q_req.set = SET_MAX_W'(addr_ext & ((64'd1 << IDX_BITS) - 64'd1));
		end
	end
endmodule
`default_nettype wire

// ===== design/sacts_fifo.sv =====
`default_nettype none
module sacts_fifo
	import sacts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  req_t      push_req,
	input  wire logic pop,
	output logic      empty,
	output logic      full,
	output req_t      head
);
	req_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_req;
	end
endmodule
`default_nettype wire

// ===== design/sacts_back.sv =====
`default_nettype none
module sacts_back
	import sacts_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic q_empty,
	input  req_t      q_head,
	output logic      q_pop,
	output logic      store_ready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output res_t      res
);
	`include "set_assoc_cache_tag_store_core_assert.svh"

	localparam int ROW_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W = $clog2(WAYS + 1);
	localparam int CMP_W = CNT_W + QUOTA_W + 1;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EX   = 2'd2;

	line_t [WAYS-1:0] mem_q [SETS];

	logic [1:0]       state_q;
	logic [ROW_W-1:0] clr_q;
	line_t [WAYS-1:0] row_s1;
	req_t             req_s1;
	logic             out_valid_q;
	res_t             out_q;

	logic             fire;
	logic             hit_any;
	logic [WAY_W-1:0] hit_way;
	logic             inv_any;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] lru_all;
	logic             f0_any, f1_any;
	logic [WAY_W-1:0] lru_c0, lru_c1;
	logic [WAYS-1:0]  own1;
	logic [CNT_W-1:0] c1, c0;
	logic             from_core;
	logic [WAY_W-1:0] victim;
	logic             mem_we;
	line_t [WAYS-1:0] row_new;
	res_t             res_d;
	logic [ROW_W-1:0] row_idx;

	assign store_ready = (state_q != ST_CLR);
	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign fire        = (state_q == ST_EX) && (!out_valid_q || m_tready);
	assign m_tvalid    = out_valid_q;
	assign res         = out_q;
	assign row_idx     = req_s1.set[ROW_W-1:0];

	always_comb begin
		logic [STAMP_W-1:0] s_all, s0, s1;
		logic               any_all;
		hit_any = 1'b0; hit_way = '0;
		inv_any = 1'b0; inv_way = '0;
		any_all = 1'b0; lru_all = '0; s_all = '0;
		f0_any = 1'b0; lru_c0 = '0; s0 = '0;
		f1_any = 1'b0; lru_c1 = '0; s1 = '0;
		for (int w = 0; w < WAYS; w++) begin
			own1[w] = row_s1[w].owner;
			if (!hit_any && row_s1[w].valid && row_s1[w].tag == req_s1.tag
					&& row_s1[w].owner == req_s1.core_id) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!inv_any && !row_s1[w].valid) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(w);
			end
			if (!any_all || row_s1[w].stamp < s_all) begin
				any_all = 1'b1;
				lru_all = WAY_W'(w);
				s_all   = row_s1[w].stamp;
			end
			if (!row_s1[w].owner && (!f0_any || row_s1[w].stamp < s0)) begin
				f0_any = 1'b1;
				lru_c0 = WAY_W'(w);
				s0     = row_s1[w].stamp;
			end
			if (row_s1[w].owner && (!f1_any || row_s1[w].stamp < s1)) begin
				f1_any = 1'b1;
				lru_c1 = WAY_W'(w);
				s1     = row_s1[w].stamp;
			end
		end
	end

	assign c1 = CNT_W'($countones(own1));
	assign c0 = CNT_W'(WAYS) - c1;

	// Core 0 takes from core 1 when core 1 holds more than its share of the set.
	always_comb begin
		if (!req_s1.core_id) begin
			from_core = (CMP_W'(c1) + CMP_W'(cfg.quota)) > CMP_W'(WAYS);
		end else begin
			from_core = !(CMP_W'(c0) > CMP_W'(cfg.quota));
		end
	end

	always_comb begin
		if (inv_any) begin
			victim = inv_way;
		end else if (cfg.policy == POLICY_LRU) begin
			victim = lru_all;
		end else if (from_core && f1_any) begin
			victim = lru_c1;
		end else if (!from_core && f0_any) begin
			victim = lru_c0;
		end else begin
			victim = lru_all;
		end
	end

	always_comb begin
		row_new = row_s1;
		res_d   = '0;
		mem_we  = 1'b0;
		if (req_s1.cmd == CMD_LOOKUP) begin
			if (hit_any) begin
				mem_we                 = 1'b1;
				row_new[hit_way].stamp = req_s1.now;
				if (req_s1.wr_flag) row_new[hit_way].dirty = 1'b1;
				res_d.hit        = 1'b1;
				res_d.victim_way = 3'(hit_way);
			end
		end else begin
			mem_we                  = 1'b1;
			row_new[victim].valid   = 1'b1;
			row_new[victim].dirty   = req_s1.wr_flag;
			row_new[victim].owner   = req_s1.core_id;
			row_new[victim].tag     = req_s1.tag;
			row_new[victim].stamp   = req_s1.now;
			res_d.victim_way        = 3'(victim);
			if (row_s1[victim].valid) begin
				res_d.evicted_valid = 1'b1;
				res_d.evicted_dirty = row_s1[victim].dirty;
				res_d.evicted_tag   = row_s1[victim].tag;
				res_d.evicted_core  = row_s1[victim].owner;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == ROW_W'(SETS - 1)) state_q <= ST_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (!q_empty) state_q <= ST_EX;
				end
				ST_EX: begin
					if (fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_s1 <= mem_q[q_head.set[ROW_W-1:0]];
			req_s1 <= q_head;
		end
		if (state_q == ST_CLR) begin
			mem_q[clr_q] <= '0;
		end else if (fire && mem_we) begin
			mem_q[row_idx] <= row_new;
		end
		if (fire) out_q <= res_d;
	end

	`SACTS_ASSERT_NOW(a_pop_idle, q_pop, state_q == ST_IDLE, "pop outside idle")
	`SACTS_ASSERT_NOW(a_no_pop_clr, state_q == ST_CLR, !q_pop && !store_ready,
		"request taken during clearing pass")
	`SACTS_ASSERT_NEXT(a_fire_done, fire, state_q == ST_IDLE && out_valid_q,
		"finished request not presented")
	`SACTS_ASSERT_NOW(a_install_nohit, fire && req_s1.cmd == CMD_INSTALL, !res_d.hit,
		"install reported a hit")
endmodule
`default_nettype wire

// ===== design/set_assoc_cache_tag_store_core.sv =====
// Tag store of a two-core set-associative cache. Each request reads one set
// row, compares or picks a victim over all ways, and writes the row back on
// a hit or an install. Its set row is read into a register when it leaves
// the input queue and its result is registered when the store finishes it;
// the single read-modify-write of the set memory means the store takes no new
// request until the last one is done. A stalled result holds the store, and
// the two-entry input queue then fills and drops s_tready.
// After reset a clearing pass zeroes the set memory, one set per cycle, over
// all SETS sets (256 by default); s_tready stays low until it is done.
// Configuration writes (index 0 policy, index 1 core 0 way quota) are taken
// at once and should only be issued while the store is idle.
`default_nettype none
module set_assoc_cache_tag_store_core
	import sacts_pkg::*;
#(
	parameter int SETS           = DEF_SETS,
	parameter int WAYS           = DEF_WAYS,
	parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// line address, write flag, core_id, now, zero fill
	input  wire logic [((LINE_ADDR_BITS+34+7)/8)*8-1:0] s_tdata,
	// cmd
	input  wire logic                    s_tuser,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// hit, victim_way, evicted_valid, evicted_dirty, evicted_tag, evicted_core, zero fill
	output logic [OUT_DATA_W-1:0]        m_tdata,
	input  wire logic                    cfg_wr_en,
	input  wire logic                    cfg_index,
	input  wire logic [QUOTA_W-1:0]      cfg_data
);
	cfg_t cfg_q;
	logic q_full, q_empty, q_push, q_pop, store_ready;
	req_t q_req, q_head;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy <= POLICY_LRU;
			cfg_q.quota  <= QUOTA_W'(4);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POLICY: cfg_q.policy <= cfg_data[0];
				REG_QUOTA:  cfg_q.quota  <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	sacts_front #(.SETS(SETS), .LINE_ADDR_BITS(LINE_ADDR_BITS)) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.addr_in    (s_tdata[LINE_ADDR_BITS-1:0]),
		.wr_flag    (s_tdata[LINE_ADDR_BITS]),
		.core_id    (s_tdata[LINE_ADDR_BITS+1]),
		.now        (s_tdata[LINE_ADDR_BITS+33:LINE_ADDR_BITS+2]),
		.cmd        (s_tuser),
		.store_ready(store_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_req      (q_req)
	);

	sacts_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_req(q_req),
		.pop     (q_pop),
		.empty   (q_empty),
		.full    (q_full),
		.head    (q_head)
	);

	sacts_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.store_ready(store_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	assign m_tdata = {1'b0, res};
endmodule
`default_nettype wire
